/* hdl/hkc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the hot key two slot cache.
// No dependencies; the interfaces and the top level import this package.
package hkc_pkg;

    // Fixed field widths of the request and response channels
    localparam int FIELD_W = 64;
    localparam int SCORE_W = 8;
    localparam int THR_W   = 8;

    // Default key and value widths in bytes
    localparam int DEF_KEY_BYTES   = 8;
    localparam int DEF_VALUE_BYTES = 8;

    // Tracker limit and the promotion threshold after reset
    localparam logic [SCORE_W-1:0] SCORE_MAX = 8'd255;
    localparam logic [THR_W-1:0]   THR_RESET = 8'd3;

    // Request actions
    localparam logic ACT_LOOKUP  = 1'b0;
    localparam logic ACT_INSTALL = 1'b1;

    // Response status codes
    typedef enum logic [1:0] {
        ST_MISS     = 2'd0,
        ST_HIT_LAST = 2'd1,
        ST_HIT_HOT  = 2'd2,
        ST_INSTALL  = 2'd3
    } t_status;

endpackage

/* hdl/hkc_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on hkc_pkg for field widths and the status type.
interface hkc_req_if;
    import hkc_pkg::*;
    logic               valid;
    logic               ready;
    logic               action;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] value;

    modport source (output valid, output action, output key, output value, input ready);
    modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface hkc_rsp_if;
    import hkc_pkg::*;
    logic               valid;
    logic               ready;
    t_status            status;
    logic [FIELD_W-1:0] data_out;
    logic               promoted;

    modport source (output valid, output status, output data_out, output promoted, input ready);
    modport sink   (input valid, input status, input data_out, input promoted, output ready);
endinterface

interface hkc_cfg_if;
    import hkc_pkg::*;
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/hot_key_two_slot_cache.sv */
`timescale 1ns / 1ps
// Hot key cache front: input register, one pass of slot and tracker logic, result register.
// Throughput: one request per cycle while the receiver takes responses, as the slot compare
// and tracker update feed back into the state registers in one pass.
// Configuration writes are taken every cycle (ready always high).
// Reset (synchronous, active low) empties both slots and the tracker and sets the threshold to 3.
// Depends on hkc_pkg and hkc_if.
module hot_key_two_slot_cache #(
    parameter int KEY_BYTES   = hkc_pkg::DEF_KEY_BYTES,
    parameter int VALUE_BYTES = hkc_pkg::DEF_VALUE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hkc_req_if.sink     i_req,
    hkc_cfg_if.sink     i_cfg,
    hkc_rsp_if.source   o_rsp
);
    import hkc_pkg::*;

    localparam int KEY_W   = 8 * KEY_BYTES;
    localparam int VALUE_W = 8 * VALUE_BYTES;

    // Input register
    logic               r_in_valid;
    logic               r_in_action;
    logic [KEY_W-1:0]   r_in_key;
    logic [VALUE_W-1:0] r_in_value;

    // Configuration
    logic [THR_W-1:0]   r_threshold;

    // Slot and tracker state
    logic               r_last_valid, n_last_valid;
    logic [KEY_W-1:0]   r_last_key,   n_last_key;
    logic [VALUE_W-1:0] r_last_value, n_last_value;
    logic               r_hot_valid,  n_hot_valid;
    logic [KEY_W-1:0]   r_hot_key,    n_hot_key;
    logic [VALUE_W-1:0] r_hot_value,  n_hot_value;
    logic               r_cand_valid, n_cand_valid;
    logic [SCORE_W-1:0] r_cand_score, n_cand_score;
    logic [KEY_W-1:0]   r_cand_key,   n_cand_key;

    // Result register
    logic               r_out_valid;
    t_status            r_out_status, n_out_status;
    logic [VALUE_W-1:0] r_out_data,   n_out_data;
    logic               r_out_prom,   n_out_prom;

    logic               w_out_free;
    logic               w_advance;
    logic               w_hit_last;
    logic               w_hit_hot;
    logic               w_track;
    logic [SCORE_W-1:0] w_dec_score;

    // Handshake: the result register parts the two sides
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_advance   = r_in_valid && w_out_free;
    assign i_req.ready = !r_in_valid || w_out_free;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.data_out = FIELD_W'(r_out_data);
    assign o_rsp.promoted = r_out_prom;

    // Capture a request transfer, dropping unused key and value bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
        if (i_req.valid && i_req.ready) begin
            r_in_action <= i_req.action;
            r_in_key    <= i_req.key[KEY_W-1:0];
            r_in_value  <= i_req.value[VALUE_W-1:0];
        end
    end

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_threshold <= i_cfg.data;
        end
    end

    assign w_hit_last  = r_last_valid && (r_last_key == r_in_key);
    assign w_hit_hot   = r_hot_valid && (r_hot_key == r_in_key);
    assign w_dec_score = (r_cand_score != '0) ? r_cand_score - 1'b1 : '0;

    // Slot lookup, install, tracker update and promotion
    always_comb begin
        n_last_valid = r_last_valid;
        n_last_key   = r_last_key;
        n_last_value = r_last_value;
        n_hot_valid  = r_hot_valid;
        n_hot_key    = r_hot_key;
        n_hot_value  = r_hot_value;
        n_cand_valid = r_cand_valid;
        n_cand_score = r_cand_score;
        n_cand_key   = r_cand_key;
        n_out_status = ST_MISS;
        n_out_data   = '0;
        n_out_prom   = 1'b0;
        w_track      = 1'b0;

        if (r_in_action == ACT_INSTALL) begin
            n_last_valid = 1'b1;
            n_last_key   = r_in_key;
            n_last_value = r_in_value;
            // refresh a hot slot holding the same key
            if (w_hit_hot) begin
                n_hot_value = r_in_value;
            end
            n_out_status = ST_INSTALL;
            n_out_data   = r_in_value;
            w_track      = 1'b1;
        end else if (w_hit_last) begin
            n_out_status = ST_HIT_LAST;
            n_out_data   = r_last_value;
            w_track      = 1'b1;
        end else if (w_hit_hot) begin
            n_last_valid = 1'b1;
            n_last_key   = r_in_key;
            n_last_value = r_hot_value;
            n_out_status = ST_HIT_HOT;
            n_out_data   = r_hot_value;
            w_track      = 1'b1;
        end

        // Majority-vote tracker: bump on match, else decay and replace at zero
        if (w_track) begin
            if (!r_cand_valid) begin
                n_cand_valid = 1'b1;
                n_cand_key   = r_in_key;
                n_cand_score = SCORE_W'(1);
            end else if (r_cand_key == r_in_key) begin
                if (r_cand_score != SCORE_MAX) begin
                    n_cand_score = r_cand_score + 1'b1;
                end
            end else if (w_dec_score == '0) begin
                n_cand_key   = r_in_key;
                n_cand_score = SCORE_W'(1);
            end else begin
                n_cand_score = w_dec_score;
            end

            // promote the tracked key once its score reaches the threshold
            if ((n_cand_score >= r_threshold) && (n_cand_key == r_in_key)) begin
                n_hot_valid = 1'b1;
                n_hot_key   = r_in_key;
                n_hot_value = n_out_data;
                n_out_prom  = 1'b1;
            end
        end
    end

    // Advance state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_valid <= 1'b0;
            r_hot_valid  <= 1'b0;
            r_cand_valid <= 1'b0;
            r_cand_score <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_advance) begin
                r_last_valid <= n_last_valid;
                r_hot_valid  <= n_hot_valid;
                r_cand_valid <= n_cand_valid;
                r_cand_score <= n_cand_score;
                r_out_valid  <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
        if (w_advance) begin
            r_last_key   <= n_last_key;
            r_last_value <= n_last_value;
            r_hot_key    <= n_hot_key;
            r_hot_value  <= n_hot_value;
            r_cand_key   <= n_cand_key;
            r_out_status <= n_out_status;
            r_out_data   <= n_out_data;
            r_out_prom   <= n_out_prom;
        end
    end

    // A live tracker entry never carries a zero score
    a_cand_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cand_valid |-> (r_cand_score != '0))
        else $error("tracker valid with zero score");

    // A miss returns zero data and never promotes
    a_miss_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_MISS)) |-> (!r_out_prom && (r_out_data == '0)))
        else $error("miss carried data or promotion");

    // An install leaves its key in the last slot
    a_install_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_action == ACT_INSTALL)) |=>
            (r_last_valid && (r_last_key == $past(r_in_key))))
        else $error("install did not set last slot");

    // A promotion leaves the hot slot valid
    a_prom_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && n_out_prom) |=> r_hot_valid)
        else $error("promotion left hot slot empty");

endmodule

/* tb/sv/hot_key_two_slot_cache_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the hot key two slot cache: directed cases, saturation,
// a long receiver hold-off and random lookup/install traffic, checked against a shadow model.
// Depends on hkc_pkg, the hkc_if channel interfaces and hot_key_two_slot_cache.
module hot_key_two_slot_cache_test;
    import hkc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        t_status            status;
        logic [FIELD_W-1:0] data;
        logic               promoted;
    } t_cache_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hkc_req_if req_ch();
    hkc_rsp_if rsp_ch();
    hkc_cfg_if cfg_ch();

    hot_key_two_slot_cache DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the cache slots, the frequency tracker and the threshold
    logic [THR_W-1:0]   promote_thr;
    logic               last_ok;
    logic [FIELD_W-1:0] last_k;
    logic [FIELD_W-1:0] last_v;
    logic               hot_ok;
    logic [FIELD_W-1:0] hot_k;
    logic [FIELD_W-1:0] hot_v;
    logic               trk_ok;
    logic [SCORE_W-1:0] trk_score;
    logic [FIELD_W-1:0] trk_k;

    t_cache_reply       expected_replies[$];
    int                 fail_count    = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 recv_hold     = 0;
    int                 quiet_cycles  = 0;
    logic [FIELD_W-1:0] key_pool[4];

    // Free-running clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [FIELD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic void clear_shadow();
        promote_thr = THR_RESET;
        last_ok     = 1'b0;
        last_k      = '0;
        last_v      = '0;
        hot_ok      = 1'b0;
        hot_k       = '0;
        hot_v       = '0;
        trk_ok      = 1'b0;
        trk_score   = '0;
        trk_k       = '0;
    endfunction

    // Majority-vote tracker update, then promote the key into the hot slot at threshold
    function automatic logic count_and_promote(input logic [FIELD_W-1:0] k,
                                               input logic [FIELD_W-1:0] v);
        if (!trk_ok) begin
            trk_k     = k;
            trk_score = 8'd1;
            trk_ok    = 1'b1;
        end else if (trk_k == k) begin
            if (trk_score != SCORE_MAX)
                trk_score = trk_score + 8'd1;
        end else begin
            if (trk_score != 0)
                trk_score = trk_score - 8'd1;
            if (trk_score == 0) begin
                trk_k     = k;
                trk_score = 8'd1;
            end
        end
        if (trk_score >= promote_thr && trk_k == k) begin
            hot_k  = k;
            hot_v  = v;
            hot_ok = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Work out the reply to one request and advance the shadow state
    function automatic t_cache_reply predict_reply(input logic act,
                                                   input logic [FIELD_W-1:0] k,
                                                   input logic [FIELD_W-1:0] v);
        t_cache_reply r;
        r.status   = ST_MISS;
        r.data     = '0;
        r.promoted = 1'b0;
        if (act == ACT_INSTALL) begin
            last_k  = k;
            last_v  = v;
            last_ok = 1'b1;
            if (hot_ok && hot_k == k)
                hot_v = v;
            r.promoted = count_and_promote(k, v);
            r.status   = ST_INSTALL;
            r.data     = v;
        end else if (last_ok && last_k == k) begin
            r.data     = last_v;
            r.promoted = count_and_promote(k, last_v);
            r.status   = ST_HIT_LAST;
        end else if (hot_ok && hot_k == k) begin
            r.data     = hot_v;
            last_k     = k;
            last_v     = hot_v;
            last_ok    = 1'b1;
            r.promoted = count_and_promote(k, r.data);
            r.status   = ST_HIT_HOT;
        end
        return r;
    endfunction

    // Response ready: hold off on request, otherwise stall at random
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold = recv_hold - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each response transfer with the oldest expected reply
    always @(posedge i_clk) begin
        t_cache_reply want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected response, expected none, actual status %0d data %h",
                         $time, rsp_ch.status, rsp_ch.data_out);
                fail_count++;
            end else begin
                want = expected_replies.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.data_out !== want.data) begin
                    $display("%0t: data_out mismatch, expected %h, actual %h",
                             $time, want.data, rsp_ch.data_out);
                    fail_count++;
                end
                if (rsp_ch.promoted !== want.promoted) begin
                    $display("%0t: promoted mismatch, expected %0b, actual %0b",
                             $time, want.promoted, rsp_ch.promoted);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transfer
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request, idling first at random; valid stays high until the next call
    task automatic send_item(input logic act, input logic [FIELD_W-1:0] k,
                             input logic [FIELD_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.key    <= k;
        req_ch.value  <= v;
        do @(posedge i_clk); while (!req_ch.ready);
        expected_replies.push_back(predict_reply(act, k, v));
        @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] thr);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= thr;
        do @(posedge i_clk); while (!cfg_ch.ready);
        promote_thr = thr;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Drop the request valid and wait for every outstanding reply
    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(negedge i_clk);
    endtask

    // Empty cache: zero and all-ones keys must miss, not hit the reset slot contents
    task automatic test_empty_cache_misses();
        send_item(ACT_LOOKUP, '0, random_word());
        send_item(ACT_LOOKUP, '1, '1);
        drain_replies();
    endtask

    // Last hit, promotion at the default threshold, hot hit copying into the last slot
    task automatic test_hit_and_promotion();
        logic [FIELD_W-1:0] ka;
        logic [FIELD_W-1:0] kb;
        ka = random_word();
        kb = random_word();
        write_threshold(THR_RESET);
        send_item(ACT_INSTALL, ka, random_word());
        send_item(ACT_LOOKUP, ka, random_word());
        send_item(ACT_LOOKUP, ka, random_word());
        send_item(ACT_INSTALL, kb, random_word());
        send_item(ACT_LOOKUP, ka, random_word());
        send_item(ACT_LOOKUP, ka, random_word());
        send_item(ACT_LOOKUP, kb, random_word());
        drain_replies();
    endtask

    // An install of the hot key refreshes the hot value
    task automatic test_install_refreshes_hot();
        logic [FIELD_W-1:0] hot_key_now;
        hot_key_now = hot_k;
        send_item(ACT_INSTALL, hot_key_now, random_word());
        send_item(ACT_INSTALL, ~hot_key_now, random_word());
        send_item(ACT_LOOKUP, hot_key_now, random_word());
        drain_replies();
    endtask

    // Threshold zero behaves as one; then threshold one itself
    task automatic test_threshold_extremes();
        logic [FIELD_W-1:0] kc;
        kc = random_word();
        write_threshold(8'd0);
        send_item(ACT_INSTALL, kc, random_word());
        send_item(ACT_LOOKUP, kc, random_word());
        drain_replies();
        write_threshold(8'd1);
        send_item(ACT_INSTALL, random_word(), random_word());
        drain_replies();
    endtask

    // All-zero and all-ones keys and values behave as ordinary entries
    task automatic test_zero_and_ones_keys();
        send_item(ACT_INSTALL, '0, '1);
        send_item(ACT_LOOKUP, '0, '0);
        send_item(ACT_INSTALL, '1, '0);
        send_item(ACT_LOOKUP, '1, '1);
        send_item(ACT_LOOKUP, '0, '1);
        drain_replies();
    endtask

    // Score saturates at the maximum: one foreign install must not drop it below threshold-1
    task automatic test_score_saturation();
        logic [FIELD_W-1:0] ks;
        ks = random_word();
        write_threshold(SCORE_MAX);
        send_item(ACT_INSTALL, ks, random_word());
        repeat (259)
            send_item(ACT_LOOKUP, ks, random_word());
        send_item(ACT_LOOKUP, ~ks, random_word());
        send_item(ACT_INSTALL, ~ks, random_word());
        send_item(ACT_LOOKUP, ks, random_word());
        send_item(ACT_LOOKUP, ks, random_word());
        drain_replies();
    endtask

    // Hold the receiver off while requests keep coming so the block fills and stalls
    task automatic test_backpressure_fill();
        write_threshold(8'd2);
        recv_hold = HOLD_CYCLES;
        repeat (40)
            send_item(1'($urandom_range(1)), key_pool[2'($urandom_range(3))], random_word());
        drain_replies();
    endtask

    // Mostly bursts on a small key pool, with some random noise
    task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct,
                                       input logic [THR_W-1:0] thr);
        logic [FIELD_W-1:0] k;
        int                 sent;
        int                 reps;
        sent          = 0;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        write_threshold(thr);
        foreach (key_pool[i])
            key_pool[i] = random_word();
        while (sent < n_items) begin
            if ($urandom_range(99) < 80) begin
                k = key_pool[2'($urandom_range(3))];
                if ($urandom_range(1) == 1) begin
                    send_item(ACT_INSTALL, k, random_word());
                    sent++;
                end
                reps = $urandom_range(1, 6);
                repeat (reps) begin
                    if ($urandom_range(9) == 0)
                        send_item(ACT_LOOKUP, key_pool[2'($urandom_range(3))], random_word());
                    else
                        send_item(ACT_LOOKUP, k, random_word());
                    sent++;
                end
            end else begin
                send_item(1'($urandom_range(1)), random_word(), random_word());
                sent++;
            end
        end
        drain_replies();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.action = ACT_LOOKUP;
        req_ch.key    = '0;
        req_ch.value  = '0;
        rsp_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        clear_shadow();
        foreach (key_pool[i])
            key_pool[i] = random_word();
        send_idle_pct = 17;
        recv_idle_pct = 83;

        // Hold reset low, then release it on a falling edge
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_cache_misses();
        test_hit_and_promotion();
        test_install_refreshes_hot();
        test_threshold_extremes();
        test_zero_and_ones_keys();
        test_score_saturation();
        test_backpressure_fill();
        test_random_traffic(260, 17, 83, 8'd2);
        test_random_traffic(260, 83, 17, 8'($urandom_range(1, 6)));
        test_random_traffic(260, 0, 0, 8'd1);

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/hkc_pkg.sv
hdl/hkc_if.sv
hdl/hot_key_two_slot_cache.sv
tb/sv/hot_key_two_slot_cache_test.sv
